FILE: design/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the huffman code bit packer: item kinds,
// fixed field widths and the layout of one code table entry.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int KIND_W   = 2;
  localparam int SYM_W    = 7;
  localparam int VAL_W    = 32;
  localparam int LEN_W    = 6;
  localparam int PEND_W   = 7;
  localparam int CNT3_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

FILE: design/huffman_code_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Huffman encoding stage: code table, bit accumulator and byte output.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser carries the item kind (load, encode, flush),
// tdata the symbol, code value and code length. A load writes the code table
// in the cycle of its transfer and yields no output. An encode reads the
// table, appends the code to the pending bits and emits every full byte,
// first bit in bit 7. A flush emits the partial byte padded with zeros, or
// 0x00 when on a byte boundary. tlast marks the last byte of one item.
// An encode or flush transfer shows its first byte after the lookup stage
// register (table read) and then the output register. Throughput: one item
// per cycle while each item yields at most one byte and the receiver takes
// it; an item yielding more bytes holds the output until its last byte is
// taken, one byte per transfer, and the next item waits in the lookup stage
// behind it, as set by the table read port and single output byte register.
// When the receiver stalls, the output byte holds and s_axis_tready drops
// once the lookup stage is blocked. Reset clears the pending bits and the
// pipeline valid state; the code table is not cleared and must be loaded
// before a symbol is encoded.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer
  import hcbp_pkg::*;
#(
  parameter int CODE_LEN_MAX = 32,
  parameter int SYMBOLS      = 128
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // symbol [6:0], code_value [38:7], code_length [44:39], zero [47:45]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // kind [1:0]
  input  logic [KIND_W-1:0]      s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_byte [7:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  localparam int AccW  = CODE_LEN_MAX + PEND_W;
  localparam int TotW  = $clog2(AccW + 1);
  localparam int CntW  = $clog2(AccW / BYTE_W + 1);
  localparam int AddrW = $clog2(SYMBOLS);

  logic [SYM_W-1:0] in_sym;
  logic [VAL_W-1:0] in_val;
  logic [LEN_W-1:0] in_len;
  kind_e            in_kind;
  logic             in_xfer;
  logic             sym_ok;
  logic             do_load;
  logic             do_read;
  entry_t           wr_entry;
  entry_t           rd_entry;

  logic             s1_valid_q, s1_valid_d;
  logic             s1_flush_q;
  logic             s1_adv;

  logic [PEND_W-1:0] pend_q, pend_d;
  logic [CNT3_W-1:0] pcnt_q, pcnt_d;

  logic [AccW-1:0]   enc_word;
  logic [TotW-1:0]   enc_tot;
  logic [BYTE_W-1:0] flush_byte;
  logic [AccW-1:0]   res_word;
  logic [TotW-1:0]   res_pos;
  logic [CntW-1:0]   res_n;

  logic [AccW-1:0] out_w_q, out_w_d;
  logic [TotW-1:0] out_pos_q, out_pos_d;
  logic [CntW-1:0] out_cnt_q, out_cnt_d;
  logic            out_xfer;
  logic            out_free;

  assign in_sym  = s_axis_tdata[SYM_W-1:0];
  assign in_val  = s_axis_tdata[SYM_W+VAL_W-1:SYM_W];
  assign in_len  = s_axis_tdata[SYM_W+VAL_W+LEN_W-1:SYM_W+VAL_W];
  assign in_kind = kind_e'(s_axis_tuser);
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign sym_ok  = 32'(in_sym) < SYMBOLS;
  assign do_load = in_xfer && (in_kind == KIND_LOAD) && sym_ok;
  assign do_read = in_xfer && (in_kind == KIND_ENCODE) && sym_ok;

  always_comb begin
    wr_entry.value = in_val;
    if (32'(in_len) > CODE_LEN_MAX) begin
      wr_entry.len = LEN_W'(CODE_LEN_MAX);
    end else begin
      wr_entry.len = in_len;
    end
  end

  hcbp_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(SYMBOLS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (do_load),
    .waddr_i(AddrW'(in_sym)),
    .wdata_i(wr_entry),
    .re_i   (do_read),
    .raddr_i(AddrW'(in_sym)),
    .rdata_o(rd_entry)
  );

  // bit accumulation for the item in the lookup stage
  always_comb begin
    enc_word = (AccW'(pend_q) << rd_entry.len)
             | (AccW'(rd_entry.value) & ~({AccW{1'b1}} << rd_entry.len));
    enc_tot  = TotW'(pcnt_q) + TotW'(rd_entry.len);
    if (pcnt_q != '0) begin
      flush_byte = BYTE_W'({1'b0, pend_q} << (4'(BYTE_W) - {1'b0, pcnt_q}));
    end else begin
      flush_byte = '0;
    end
    if (s1_flush_q) begin
      res_word = AccW'(flush_byte);
      res_pos  = '0;
      res_n    = CntW'(1);
      pend_d   = '0;
      pcnt_d   = '0;
    end else begin
      res_word = enc_word;
      res_pos  = enc_tot - TotW'(BYTE_W);
      res_n    = CntW'(enc_tot >> 3);
      pcnt_d   = enc_tot[CNT3_W-1:0];
      pend_d   = enc_word[PEND_W-1:0] & ~({PEND_W{1'b1}} << enc_tot[CNT3_W-1:0]);
    end
  end

  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign out_free = (out_cnt_q == '0) || (out_xfer && (out_cnt_q == CntW'(1)));
  assign s1_adv   = s1_valid_q && ((res_n == '0) || out_free);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (in_xfer) begin
      s1_valid_d = do_read || (in_kind == KIND_FLUSH);
    end
  end

  always_comb begin
    out_w_d   = out_w_q;
    out_pos_d = out_pos_q;
    out_cnt_d = out_cnt_q;
    if (out_xfer) begin
      out_cnt_d = out_cnt_q - CntW'(1);
      out_pos_d = out_pos_q - TotW'(BYTE_W);
    end
    if (s1_adv && (res_n != '0)) begin
      out_w_d   = res_word;
      out_pos_d = res_pos;
      out_cnt_d = res_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      pend_q     <= '0;
      pcnt_q     <= '0;
      out_cnt_q  <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      out_cnt_q  <= out_cnt_d;
      if (s1_adv) begin
        pend_q <= pend_d;
        pcnt_q <= pcnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_flush_q <= (in_kind == KIND_FLUSH);
    end
    out_w_q   <= out_w_d;
    out_pos_q <= out_pos_d;
  end

  assign m_axis_tvalid = out_cnt_q != '0;
  assign m_axis_tdata  = OUT_TDATA_W'(out_w_q >> out_pos_q);
  assign m_axis_tlast  = out_cnt_q == CntW'(1);

endmodule

FILE: design/hcbp_ram.sv
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hcbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the huffman code bit packer. Drives load, encode, flush and
// unused-kind items on the input stream with random gaps and output stalls,
// predicts every packed byte from a local copy of the code table and the
// pending bits, and checks each output transfer in order against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import hcbp_pkg::*;
();

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int MAX_LEN     = 32;
  localparam int NUM_SYMS    = 128;
  localparam int IDLE_PCT    = 27;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // symbol [6:0], code_value [38:7], code_length [44:39], zero [47:45]
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // kind [1:0]
  logic [KIND_W-1:0]      s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // out_byte [7:0]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  entry_t            code_tab [NUM_SYMS];
  bit                loaded   [NUM_SYMS];
  logic [SYM_W-1:0]  loaded_syms[$];
  logic [PEND_W-1:0] pend_bits;
  logic [CNT3_W-1:0] pend_cnt;
  packed_byte_t      expected_bytes[$];
  int                n_errors;
  int                n_cycles;
  bit                no_idle;

  huffman_code_bit_packer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  // updates the table and pending bits, queues the bytes an item yields
  function automatic void pack_item(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                                    input logic [VAL_W-1:0] val, input logic [LEN_W-1:0] len);
    logic [BYTE_W-1:0] acc;
    int                cnt;
    int                tmp;
    int                first_new;
    packed_byte_t      pb;
    first_new = expected_bytes.size();
    case (kind)
      KIND_LOAD: begin
        code_tab[sym].value = val;
        code_tab[sym].len   = (len > MAX_LEN) ? LEN_W'(MAX_LEN) : len;
        if (!loaded[sym]) begin
          loaded[sym] = 1'b1;
          loaded_syms.push_back(sym);
        end
      end
      KIND_ENCODE: begin
        acc = {1'b0, pend_bits};
        cnt = pend_cnt;
        for (int k = int'(code_tab[sym].len); k > 0; k--) begin
          acc = {acc[BYTE_W-2:0], code_tab[sym].value[k-1]};
          cnt++;
          if (cnt == 8) begin
            pb.data = acc;
            pb.last = 1'b0;
            expected_bytes.push_back(pb);
            acc = '0;
            cnt = 0;
          end
        end
        pend_bits = acc[PEND_W-1:0];
        pend_cnt  = CNT3_W'(cnt);
        if (expected_bytes.size() > first_new)
          expected_bytes[expected_bytes.size()-1].last = 1'b1;
      end
      KIND_FLUSH: begin
        tmp = pend_bits;
        tmp = (pend_cnt != 0) ? (tmp << (8 - int'(pend_cnt))) : 0;
        pb.data = tmp[BYTE_W-1:0];
        pb.last = 1'b1;
        expected_bytes.push_back(pb);
        pend_bits = '0;
        pend_cnt  = '0;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                           input logic [VAL_W-1:0] val, input logic [LEN_W-1:0] len);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b000, len, val, sym};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pack_item(kind, sym, val, len);
  endtask

  function automatic logic [LEN_W-1:0] random_len();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 75) return LEN_W'($urandom_range(12, 1));
    if (r < 88) return LEN_W'($urandom_range(32, 13));
    return LEN_W'($urandom_range(63, 33));
  endfunction

  task automatic send_random_item();
    int               r;
    logic [SYM_W-1:0] sym;
    r   = $urandom_range(99);
    sym = SYM_W'($urandom_range(NUM_SYMS - 1));
    if (r < 25) begin
      send_item(KIND_LOAD, sym, $urandom, random_len());
    end else if (r < 85) begin
      if (!loaded[sym]) sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
      send_item(KIND_ENCODE, sym, $urandom, LEN_W'($urandom_range(63)));
    end else if (r < 95) begin
      send_item(KIND_FLUSH, sym, $urandom, LEN_W'($urandom_range(63)));
    end else begin
      send_item(KIND_UNUSED, sym, $urandom, LEN_W'($urandom_range(63)));
    end
  endtask

  always @(posedge clk_i) begin
    packed_byte_t exp_b;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected output byte %h last %b", $time, m_axis_tdata, m_axis_tlast);
        n_errors++;
      end else begin
        exp_b = expected_bytes.pop_front();
        if (m_axis_tdata !== exp_b.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, exp_b.data, m_axis_tdata);
          n_errors++;
        end
        if (m_axis_tlast !== exp_b.last) begin
          $display("%0t: last expected %b actual %b", $time, exp_b.last, m_axis_tlast);
          n_errors++;
        end
      end
    end
  end

  task automatic test_directed_cases();
    send_item(KIND_LOAD, 7'd0, 32'hFFFF_FFFF, 6'd32);
    send_item(KIND_LOAD, 7'd127, 32'h0000_00A5, 6'd8);
    // stray value bits above the code length
    send_item(KIND_LOAD, 7'd1, 32'hFFFF_FFFE, 6'd3);
    // length above the maximum saturates
    send_item(KIND_LOAD, 7'd2, 32'h1234_5678, 6'd63);
    send_item(KIND_LOAD, 7'd3, 32'hDEAD_BEEF, 6'd0);
    send_item(KIND_UNUSED, 7'd4, 32'hFFFF_FFFF, 6'd63);
    // flush on a byte boundary
    send_item(KIND_FLUSH, 7'd0, 32'h0, 6'd0);
    send_item(KIND_ENCODE, 7'd1, 32'h0, 6'd0);
    send_item(KIND_ENCODE, 7'd3, 32'h0, 6'd0);
    send_item(KIND_FLUSH, 7'd127, 32'hFFFF_FFFF, 6'd63);
    send_item(KIND_ENCODE, 7'd0, 32'h0, 6'd0);
    send_item(KIND_ENCODE, 7'd1, 32'h0, 6'd0);
    send_item(KIND_ENCODE, 7'd2, 32'h0, 6'd0);
    send_item(KIND_ENCODE, 7'd127, 32'h0, 6'd0);
    send_item(KIND_FLUSH, 7'd0, 32'h0, 6'd0);
    send_item(KIND_LOAD, 7'd1, 32'h0000_0001, 6'd7);
    send_item(KIND_ENCODE, 7'd1, 32'h0, 6'd0);
    send_item(KIND_ENCODE, 7'd1, 32'h0, 6'd0);
    send_item(KIND_ENCODE, 7'd0, 32'h0, 6'd0);
    send_item(KIND_FLUSH, 7'd0, 32'h0, 6'd0);
  endtask

  task automatic test_random_stream();
    no_idle = 1'b0;
    repeat (300) send_random_item();
  endtask

  task automatic test_no_idle_burst();
    no_idle = 1'b1;
    repeat (100) send_random_item();
    no_idle = 1'b0;
  endtask

  initial begin
    n_errors      = 0;
    n_cycles      = 0;
    no_idle       = 1'b0;
    pend_bits     = '0;
    pend_cnt      = '0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_stream();
    test_no_idle_burst();
    s_axis_tvalid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/hcbp_pkg.sv
design/hcbp_ram.sv
design/huffman_code_bit_packer.sv
tb/tb.sv
